// File: sv/lookup2_byte_hash_macros.svh
// Assertion shorthands for the hash engine and its checker.
// Every assertion samples on clk and is off while rst_n is low.
`ifndef LOOKUP2_BYTE_HASH_MACROS_SVH
`define LOOKUP2_BYTE_HASH_MACROS_SVH

// Same-cycle implication.
`define L2H_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define L2H_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/l2h_pkg.sv
`default_nettype none

package l2h_pkg;

    localparam logic [31:0] INIT_AB = 32'h9e3779b9;
    localparam logic [31:0] INIT_C  = 32'h9b9773e9;

    localparam int unsigned BLOCK_LEN = 12;
    localparam int unsigned BUF_DEPTH = BLOCK_LEN - 1;
    localparam int unsigned MIX_ROWS  = 9;

    typedef logic [3:0] pos_t;
    typedef logic [4:0] shamt_t;

    typedef enum logic [1:0] {
        MIX_A,
        MIX_B,
        MIX_C
    } mix_kind_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } words_t;

    // Work handed from the byte front end to the mixing pipeline.
    typedef struct packed {
        logic        blk;
        logic        fin;
        logic [31:0] blk_a;
        logic [31:0] blk_b;
        logic [31:0] blk_c;
        logic [31:0] tail_a;
        logic [31:0] tail_b;
        logic [31:0] tail_c;
        logic [31:0] length;
    } front_job_t;

    // Travels alongside the first mix so the finish step knows what to add.
    typedef struct packed {
        logic        blk;
        logic        fin;
        logic [31:0] tail_a;
        logic [31:0] tail_b;
        logic [31:0] c_add;
    } side_t;

    localparam words_t INIT_WORDS = '{a: INIT_AB, b: INIT_AB, c: INIT_C};

    localparam shamt_t MIX_SHIFT [MIX_ROWS] = '{
        5'd13, 5'd8, 5'd13, 5'd12, 5'd16, 5'd5, 5'd3, 5'd10, 5'd15
    };

    // One row of the mix: update a single word from the other two.
    function automatic words_t mix_row(words_t w, mix_kind_t kind, shamt_t sh);
        words_t r;
        r = w;
        unique case (kind)
            MIX_A:   r.a = (w.a - w.b - w.c) ^ (w.c >> sh);
            MIX_B:   r.b = (w.b - w.c - w.a) ^ (w.a << sh);
            MIX_C:   r.c = (w.c - w.a - w.b) ^ (w.b >> sh);
            default: r = w;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: sv/l2h_front.sv
`default_nettype none

module l2h_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic                 key_valid,
    input  logic [7:0]           data_byte,
    input  logic                 byte_present,
    input  logic                 is_last,
    output logic                 job_valid,
    output l2h_pkg::front_job_t  job
);
    import l2h_pkg::*;

    logic [7:0] buf_reg  [BUF_DEPTH];
    logic [7:0] buf_next [BUF_DEPTH];
    logic [7:0] tail_byte [BUF_DEPTH];
    pos_t        pos_reg, pos_next, pos_fill;
    logic [31:0] len_reg, len_next, len_fill;
    logic        accept;
    logic        blk_done;
    logic        job_valid_reg, job_valid_next;
    front_job_t  job_reg, job_next;

    always_comb
    begin
        accept   = key_valid && advance;
        blk_done = byte_present && (pos_reg == pos_t'(BUF_DEPTH));

        for (int i = 0; i < BUF_DEPTH; i++)
        begin
            buf_next[i] = (byte_present && !blk_done && pos_reg == pos_t'(i)) ?
                          data_byte : buf_reg[i];
        end

        if (!byte_present)
            pos_fill = pos_reg;
        else if (blk_done)
            pos_fill = '0;
        else
            pos_fill = pos_reg + pos_t'(1);

        len_fill = len_reg + 32'(byte_present);

        // Drop buffered bytes at or above the fill point: they are stale.
        for (int i = 0; i < BUF_DEPTH; i++)
        begin
            tail_byte[i] = (pos_t'(i) < pos_fill) ? buf_next[i] : 8'd0;
        end

        job_next.blk    = blk_done;
        job_next.fin    = is_last;
        job_next.blk_a  = {buf_reg[3], buf_reg[2], buf_reg[1], buf_reg[0]};
        job_next.blk_b  = {buf_reg[7], buf_reg[6], buf_reg[5], buf_reg[4]};
        job_next.blk_c  = {data_byte, buf_reg[10], buf_reg[9], buf_reg[8]};
        job_next.tail_a = {tail_byte[3], tail_byte[2], tail_byte[1], tail_byte[0]};
        job_next.tail_b = {tail_byte[7], tail_byte[6], tail_byte[5], tail_byte[4]};
        // Low byte of c is kept for the length.
        job_next.tail_c = {tail_byte[10], tail_byte[9], tail_byte[8], 8'd0};
        job_next.length = len_fill;

        pos_next       = is_last ? '0 : pos_fill;
        len_next       = is_last ? '0 : len_fill;
        job_valid_next = accept && (blk_done || is_last);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            len_reg       <= '0;
            job_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                pos_reg <= pos_next;
                len_reg <= len_next;
            end
            if (advance)
                job_valid_reg <= job_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            buf_reg <= buf_next;
            job_reg <= job_next;
        end
    end

    assign job_valid = job_valid_reg;
    assign job       = job_reg;

endmodule

`default_nettype wire

// File: sv/l2h_mix.sv
`default_nettype none

module l2h_mix (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic             in_valid,
    input  l2h_pkg::words_t  in_words,
    output logic             out_valid,
    output l2h_pkg::words_t  out_words
);
    import l2h_pkg::*;

    logic   valid_reg  [MIX_ROWS];
    words_t words_reg  [MIX_ROWS];
    words_t words_next [MIX_ROWS];

    // One mix row per stage.
    for (genvar k = 0; k < MIX_ROWS; k++)
    begin : g_row
        localparam mix_kind_t KIND = mix_kind_t'(k % 3);
        logic   valid_prev;
        words_t words_prev;

        if (k == 0)
        begin : g_first
            assign valid_prev = in_valid;
            assign words_prev = in_words;
        end
        else
        begin : g_chain
            assign valid_prev = valid_reg[k-1];
            assign words_prev = words_reg[k-1];
        end

        assign words_next[k] = mix_row(words_prev, KIND, MIX_SHIFT[k]);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (advance)
                valid_reg[k] <= valid_prev;
        end

        always_ff @(posedge clk)
        begin
            if (advance)
                words_reg[k] <= words_next[k];
        end
    end

    assign out_valid = valid_reg[MIX_ROWS-1];
    assign out_words = words_reg[MIX_ROWS-1];

endmodule

`default_nettype wire

// File: sv/lookup2_byte_hash.sv
// Byte-serial lookup2 hash: takes one key byte per cycle on the key channel and
// returns the 32-bit hash (hash_low) and the upper half of the 64-bit hash
// (hash_high) as one word on the hash channel for each item marked is_last. Keys
// may follow each other with no gap. Each 12-byte block and the finish each go
// through a nine-stage mix pipeline, one mix row per stage, so a byte is taken
// every cycle and key_stall rises only while a result sits unclaimed in the
// output register and the next one has reached the end of the pipeline.
`default_nettype none

module lookup2_byte_hash (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        key_valid,
    output logic        key_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        is_last,
    output logic        hash_valid,
    input  logic        hash_stall,
    output logic [31:0] hash_low,
    output logic [31:0] hash_high
);
    import l2h_pkg::*;

    logic       advance;
    logic       fj_valid;
    front_job_t fj;

    logic   a_valid_reg;
    words_t a_words_reg, a_words_next;
    side_t  a_side_reg, a_side_next;

    words_t state_reg;
    side_t  side_reg [MIX_ROWS];
    side_t  side_last;

    logic   m1_valid;
    words_t m1_words;

    logic   j_valid_reg, j_valid_next;
    words_t j_words_reg, j_words_next;
    words_t j_base;

    logic   m2_valid;
    words_t m2_words;

    logic        hash_valid_reg;
    logic [31:0] hash_low_reg, hash_high_reg;

    // Freeze everything only when a finished hash cannot enter the output register.
    assign advance   = !(m2_valid && hash_valid_reg && hash_stall);
    assign key_stall = !advance;

    l2h_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .key_valid    (key_valid),
        .data_byte    (data_byte),
        .byte_present (byte_present),
        .is_last      (is_last),
        .job_valid    (fj_valid),
        .job          (fj)
    );

    // Absorb a block into the running words.
    always_comb
    begin
        a_words_next.a    = state_reg.a + fj.blk_a;
        a_words_next.b    = state_reg.b + fj.blk_b;
        a_words_next.c    = state_reg.c + fj.blk_c;
        a_side_next.blk    = fj.blk;
        a_side_next.fin    = fj.fin;
        a_side_next.tail_a = fj.tail_a;
        a_side_next.tail_b = fj.tail_b;
        a_side_next.c_add  = fj.length + fj.tail_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (advance)
            a_valid_reg <= fj_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_words_reg <= a_words_next;
            a_side_reg  <= a_side_next;
        end
    end

    l2h_mix u_block_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (a_valid_reg),
        .in_words  (a_words_reg),
        .out_valid (m1_valid),
        .out_words (m1_words)
    );

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            side_reg[0] <= a_side_reg;
            for (int k = 1; k < MIX_ROWS; k++)
                side_reg[k] <= side_reg[k-1];
        end
    end

    assign side_last = side_reg[MIX_ROWS-1];

    // Finish: a job without a block picks up the words the last block left.
    always_comb
    begin
        j_base         = side_last.blk ? m1_words : state_reg;
        j_words_next.a = j_base.a + side_last.tail_a;
        j_words_next.b = j_base.b + side_last.tail_b;
        j_words_next.c = j_base.c + side_last.c_add;
        j_valid_next   = m1_valid && side_last.fin;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= INIT_WORDS;
            j_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            j_valid_reg <= j_valid_next;
            priority if (m1_valid && side_last.fin)
                state_reg <= INIT_WORDS;
            else if (m1_valid && side_last.blk)
                state_reg <= m1_words;
            else
                state_reg <= state_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            j_words_reg <= j_words_next;
    end

    l2h_mix u_final_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (j_valid_reg),
        .in_words  (j_words_reg),
        .out_valid (m2_valid),
        .out_words (m2_words)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hash_valid_reg <= 1'b0;
        else if (advance && m2_valid)
            hash_valid_reg <= 1'b1;
        else if (!hash_stall)
            hash_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && m2_valid)
        begin
            hash_low_reg  <= m2_words.c;
            hash_high_reg <= m2_words.a;
        end
    end

    assign hash_valid = hash_valid_reg;
    assign hash_low   = hash_low_reg;
    assign hash_high  = hash_high_reg;

endmodule

`default_nettype wire

// File: sv/lookup2_byte_hash_checker.sv
`default_nettype none

`include "lookup2_byte_hash_macros.svh"

module lookup2_byte_hash_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        key_stall,
    input logic        hash_valid,
    input logic        hash_stall,
    input logic [31:0] hash_low,
    input logic [31:0] hash_high
);

    // A held hash word keeps its value.
    `L2H_ASSERT_NEXT(a_hash_hold, hash_valid && hash_stall, $stable(hash_low) && $stable(hash_high), "hash word changed while stalled")

    // Backpressure on keys comes only from an unclaimed hash word.
    `L2H_ASSERT_NOW(a_stall_cause, key_stall, hash_valid && hash_stall, "key stalled without a held hash word")

    // While keys are held off the pending hash word must still be there.
    `L2H_ASSERT_NEXT(a_stall_keeps_word, key_stall, hash_valid, "hash word lost during key stall")

    // A new hash word loads only on a cycle the pipeline advanced.
    `L2H_ASSERT_NOW(a_load_on_advance, $rose(hash_valid), !$past(key_stall), "hash word loaded while frozen")

endmodule

bind lookup2_byte_hash lookup2_byte_hash_checker u_checker (.*);

`default_nettype wire
